// ===== rtl/hsv_pkg.sv =====
`default_nettype none

package hsv_pkg;

    // Input ranges: hue in sixteenths of a degree, percentages in sixteenths
    localparam logic [12:0] HUE_MAX     = 13'd5760;
    localparam logic [10:0] PCT_MAX     = 11'd1600;
    localparam int          SECTOR_SPAN = 960;

    // Q1.16 one
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Exact reciprocal for floor(n / 100), n < 2**23
    localparam logic [23:0] RECIP_100       = 24'd10737419;
    localparam int          RECIP_100_SHIFT = 30;
    // Exact reciprocal for floor(n / 30), n < 2**21
    localparam logic [21:0] RECIP_30        = 22'd2236963;
    localparam int          RECIP_30_SHIFT  = 26;

    // Bias terms after the common factors are pulled out of the divisors
    localparam logic [22:0] PCT_BIAS  = 23'd50;
    localparam logic [20:0] FRAC_BIAS = 21'd15;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    // After clamp and hue split
    typedef struct packed {
        logic [22:0] sat_num;
        logic [22:0] val_num;
        logic [20:0] frac_num;
        t_sector     sector;
    } t_split;

    // After the constant divisions
    typedef struct packed {
        logic [16:0] s;
        logic [16:0] v;
        logic [15:0] f;
        t_sector     sector;
    } t_norm;

    // After the saturation products
    typedef struct packed {
        logic [16:0] one_m_s;
        logic [16:0] s_f;
        logic [16:0] s_omf;
        logic [16:0] v;
        t_sector     sector;
    } t_sprod;

    // After the value products
    typedef struct packed {
        logic [16:0] p;
        logic [16:0] q;
        logic [16:0] t;
        logic [16:0] v;
        t_sector     sector;
    } t_vprod;

    function automatic logic [12:0] sector_base(input t_sector sec);
        logic [12:0] base;
        case (sec)
            SEC_R_TO_Y: base = 13'(0 * SECTOR_SPAN);
            SEC_Y_TO_G: base = 13'(1 * SECTOR_SPAN);
            SEC_G_TO_C: base = 13'(2 * SECTOR_SPAN);
            SEC_C_TO_B: base = 13'(3 * SECTOR_SPAN);
            SEC_B_TO_M: base = 13'(4 * SECTOR_SPAN);
            SEC_M_TO_R: base = 13'(5 * SECTOR_SPAN);
            default:    base = 13'd0;
        endcase
        return base;
    endfunction

    // Q1.16 product, rounded half up
    function automatic logic [16:0] q16_mul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] prod;
        prod = ({17'd0, a} * {17'd0, b}) + 34'd32768;
        return prod[32:16];
    endfunction

    // Q1.16 to 8-bit channel, rounded half up
    // 255*x + 32768 fits 24 bits, so x*256 may wrap at bit 24 and still cancel
    function automatic logic [7:0] to_channel(input logic [16:0] x);
        logic [23:0] acc;
        acc = {x[15:0], 8'd0} - {7'd0, x} + 24'd32768;
        return acc[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
`default_nettype none

// Channel   Direction  Ports           Payload
// s_axis    in         tvalid/tready   tdata[39:0]: hue, saturation, brightness
// m_axis    out        tvalid/tready   tdata[23:0]: red, green, blue
//
// One request per clock sustained while m_axis is ready; five register stages
// (clamp/split, reciprocal divide, saturation products, value products, sector
// select with channel rounding), each request passing through them in that
// order to the output register that drives m_axis.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on m_axis backs up stage by stage; empty stages keep filling, so
// s_axis keeps taking requests until every stage holds one.
//
// Saturation zero needs no special path: p, q and t all reduce to v.

module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [12:0] hue, [23:13] saturation, [34:24] brightness, [39:35] zero
    input  wire logic [39:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [23:0]      o_m_axis_tdata
);

    logic   split_valid;
    logic   split_ready;
    t_split split_data;
    logic   norm_valid;
    logic   norm_ready;
    t_norm  norm_data;
    logic   vprod_valid;
    logic   vprod_ready;
    t_vprod vprod_data;

    // Clamp inputs, fold full turn, find sector and remainder
    hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[12:0]),
        .i_sat   (i_s_axis_tdata[23:13]),
        .i_bri   (i_s_axis_tdata[34:24]),
        .i_ready (split_ready),
        .o_valid (split_valid),
        .o_data  (split_data)
    );

    // Convert to Q1.16 through exact constant reciprocals
    hsv_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (split_ready),
        .i_data  (split_data),
        .i_ready (norm_ready),
        .o_valid (norm_valid),
        .o_data  (norm_data)
    );

    // Form p, q and t over two multiply stages
    hsv_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_valid),
        .o_ready (norm_ready),
        .i_data  (norm_data),
        .i_ready (vprod_ready),
        .o_valid (vprod_valid),
        .o_data  (vprod_data)
    );

    // Pick channels by sector and round to 8 bits; output register
    hsv_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vprod_valid),
        .o_ready (vprod_ready),
        .i_data  (vprod_data),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_rgb   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/hsv_front.sv =====
`default_nettype none

module hsv_front
    import hsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [12:0] i_hue,
    input  wire logic [10:0] i_sat,
    input  wire logic [10:0] i_bri,
    input  wire logic        i_ready,
    output logic             o_valid,
    output t_split           o_data
);

    logic        r_valid;
    t_split      r_data;
    t_split      n_data;
    logic [12:0] hue_w;
    logic [10:0] sat_c;
    logic [10:0] bri_c;
    logic [2:0]  sec_cnt;
    logic [12:0] rem_full;

    always_comb begin
        // Clamp, then fold a full turn back to zero
        hue_w = (i_hue >= HUE_MAX) ? 13'd0 : i_hue;
        sat_c = (i_sat > PCT_MAX) ? PCT_MAX : i_sat;
        bri_c = (i_bri > PCT_MAX) ? PCT_MAX : i_bri;

        sec_cnt = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (hue_w >= 13'(k * SECTOR_SPAN)) begin
                sec_cnt = sec_cnt + 3'd1;
            end
        end
        n_data.sector = t_sector'(sec_cnt);
        rem_full      = hue_w - sector_base(n_data.sector);

        n_data.sat_num  = {sat_c, 12'd0} + PCT_BIAS;
        n_data.val_num  = {bri_c, 12'd0} + PCT_BIAS;
        n_data.frac_num = {rem_full[9:0], 11'd0} + FRAC_BIAS;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/hsv_recip.sv =====
`default_nettype none

module hsv_recip
    import hsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_split    i_data,
    input  wire logic i_ready,
    output logic      o_valid,
    output t_norm     o_data
);

    logic        r_valid;
    t_norm       r_data;
    t_norm       n_data;
    logic [46:0] s_prod;
    logic [46:0] v_prod;
    logic [42:0] f_prod;

    always_comb begin
        // Divide by multiplying with an exact reciprocal
        s_prod = {24'd0, i_data.sat_num} * {23'd0, RECIP_100};
        v_prod = {24'd0, i_data.val_num} * {23'd0, RECIP_100};
        f_prod = {22'd0, i_data.frac_num} * {21'd0, RECIP_30};

        n_data.s      = s_prod[RECIP_100_SHIFT +: 17];
        n_data.v      = v_prod[RECIP_100_SHIFT +: 17];
        n_data.f      = f_prod[RECIP_30_SHIFT +: 16];
        n_data.sector = i_data.sector;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/hsv_prod.sv =====
`default_nettype none

module hsv_prod
    import hsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_norm     i_data,
    input  wire logic i_ready,
    output logic      o_valid,
    output t_vprod    o_data
);

    logic   r_valid_s;
    t_sprod r_sprod;
    t_sprod n_sprod;
    logic   ready_s;
    logic   r_valid_v;
    t_vprod r_vprod;
    t_vprod n_vprod;

    // First stage: saturation times fraction terms
    always_comb begin
        n_sprod.one_m_s = ONE_Q16 - i_data.s;
        n_sprod.s_f     = q16_mul(i_data.s, {1'b0, i_data.f});
        n_sprod.s_omf   = q16_mul(i_data.s, ONE_Q16 - {1'b0, i_data.f});
        n_sprod.v       = i_data.v;
        n_sprod.sector  = i_data.sector;
    end

    // Second stage: scale by value to get p, q and t
    always_comb begin
        n_vprod.p      = q16_mul(r_sprod.v, r_sprod.one_m_s);
        n_vprod.q      = q16_mul(r_sprod.v, ONE_Q16 - r_sprod.s_f);
        n_vprod.t      = q16_mul(r_sprod.v, ONE_Q16 - r_sprod.s_omf);
        n_vprod.v      = r_sprod.v;
        n_vprod.sector = r_sprod.sector;
    end

    assign ready_s = !r_valid_v || i_ready;
    assign o_ready = !r_valid_s || ready_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_s <= 1'b0;
            r_valid_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_s <= i_valid;
            end
            if (ready_s) begin
                r_valid_v <= r_valid_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sprod <= n_sprod;
        end
        if (ready_s && r_valid_s) begin
            r_vprod <= n_vprod;
        end
    end

    assign o_valid = r_valid_v;
    assign o_data  = r_vprod;

endmodule

`default_nettype wire

// ===== rtl/hsv_out.sv =====
`default_nettype none

module hsv_out
    import hsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  t_vprod           i_data,
    input  wire logic        i_ready,
    output logic             o_valid,
    output logic [23:0]      o_rgb
);

    logic        r_valid;
    logic [23:0] r_rgb;
    logic [23:0] n_rgb;
    logic [16:0] red_x;
    logic [16:0] grn_x;
    logic [16:0] blu_x;

    always_comb begin
        case (i_data.sector)
            SEC_R_TO_Y: begin
                red_x = i_data.v; grn_x = i_data.t; blu_x = i_data.p;
            end
            SEC_Y_TO_G: begin
                red_x = i_data.q; grn_x = i_data.v; blu_x = i_data.p;
            end
            SEC_G_TO_C: begin
                red_x = i_data.p; grn_x = i_data.v; blu_x = i_data.t;
            end
            SEC_C_TO_B: begin
                red_x = i_data.p; grn_x = i_data.q; blu_x = i_data.v;
            end
            SEC_B_TO_M: begin
                red_x = i_data.t; grn_x = i_data.p; blu_x = i_data.v;
            end
            default: begin
                red_x = i_data.v; grn_x = i_data.p; blu_x = i_data.q;
            end
        endcase
        n_rgb = {to_channel(blu_x), to_channel(grn_x), to_channel(red_x)};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    import hsv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_COLORS = 2000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [12:0] hue, [23:13] saturation, [34:24] brightness, [39:35] zero
    logic [39:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] red, [15:8] green, [23:16] blue
    logic [23:0] o_m_axis_tdata;

    rgb_t        expected_colors[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int          tx_mode;     // 0: back to back, 1: random gaps

    hsv_to_rgb_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Percent in sixteenths to Q1.16, clamped and rounded half up
    function automatic longint unsigned pct_to_fraction(input logic [10:0] pct);
        longint unsigned clamped;
        clamped = (pct > PCT_MAX) ? PCT_MAX : pct;
        return (clamped * 65536 + PCT_MAX / 2) / PCT_MAX;
    endfunction

    function automatic longint unsigned fraction_mul(input longint unsigned a,
                                                     input longint unsigned b);
        return (a * b + 32768) >> 16;
    endfunction

    function automatic logic [7:0] fraction_to_level(input longint unsigned x);
        return 8'((255 * x + 32768) >> 16);
    endfunction

    function automatic rgb_t predict_rgb(input logic [12:0] hue_in,
                                         input logic [10:0] sat_in,
                                         input logic [10:0] bri_in);
        longint unsigned hue, s, v, f, p, q, t, r_x, g_x, b_x, one;
        t_sector sector;
        rgb_t    color;
        one = 65536;
        hue = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
        // a full turn lands back on red
        if (hue == HUE_MAX)
            hue = 0;
        s = pct_to_fraction(sat_in);
        v = pct_to_fraction(bri_in);
        if (s == 0) begin
            color.red   = fraction_to_level(v);
            color.green = color.red;
            color.blue  = color.red;
        end else begin
            sector = t_sector'(hue / SECTOR_SPAN);
            f = ((hue % SECTOR_SPAN) * one + SECTOR_SPAN / 2) / SECTOR_SPAN;
            p = fraction_mul(v, one - s);
            q = fraction_mul(v, one - fraction_mul(s, f));
            t = fraction_mul(v, one - fraction_mul(s, one - f));
            case (sector)
                SEC_R_TO_Y: begin r_x = v; g_x = t; b_x = p; end
                SEC_Y_TO_G: begin r_x = q; g_x = v; b_x = p; end
                SEC_G_TO_C: begin r_x = p; g_x = v; b_x = t; end
                SEC_C_TO_B: begin r_x = p; g_x = q; b_x = v; end
                SEC_B_TO_M: begin r_x = t; g_x = p; b_x = v; end
                default:    begin r_x = v; g_x = p; b_x = q; end
            endcase
            color.red   = fraction_to_level(r_x);
            color.green = fraction_to_level(g_x);
            color.blue  = fraction_to_level(b_x);
        end
        return color;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_color(input logic [12:0] hue, input logic [10:0] sat,
                              input logic [10:0] bri);
        int gap;
        gap = (tx_mode == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'd0, bri, sat, hue};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Hold off until every pending request has produced its color
    task automatic drain_pending();
        i_s_axis_tvalid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_extremes();
        tx_mode = 0;
        send_color(13'd0,    11'd0,    11'd0);
        send_color(13'd0,    11'd0,    11'd1600);
        send_color(13'd2000, 11'd0,    11'd800);
        send_color(13'd0,    11'd1600, 11'd1600);
        send_color(13'd0,    11'd1,    11'd1);
        send_color(13'd8191, 11'd2047, 11'd2047);
        send_color(13'd5761, 11'd1601, 11'd1601);
        send_color(13'd480,  11'd800,  11'd1600);
        send_color(13'd1234, 11'd1600, 11'd0);
        drain_pending();
    endtask

    task automatic test_sector_edges();
        tx_mode = 1;
        for (int k = 1; k <= 6; k++) begin
            send_color(13'(k * SECTOR_SPAN - 1), 11'd1600, 11'd1600);
            if (k < 6)
                send_color(13'(k * SECTOR_SPAN), 11'd1200, 11'd1600);
        end
        // full turn and just short of it
        send_color(13'd5760, 11'd1600, 11'd1600);
        send_color(13'd5759, 11'd1000, 11'd1300);
        drain_pending();
    endtask

    task automatic test_random();
        logic [12:0] hue;
        logic [10:0] sat, bri;
        for (int n = 0; n < RANDOM_COLORS; n++) begin
            if (n % 250 == 0)
                tx_mode = $urandom_range(0, 1);
            if (n == RANDOM_COLORS / 2)
                drain_pending();
            hue = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                              : 13'($urandom_range(0, 5760));
            sat = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(0, 1600));
            bri = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(0, 1600));
            if ($urandom_range(0, 19) == 0)
                sat = 11'd0;
            send_color(hue, sat, bri);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Receiver: modes of always ready, random stalls, and long stalls
    initial begin : receiver
        int rx_mode, rx_left, stall_left;
        rx_mode    = 0;
        rx_left    = 0;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(50, 300);
            end
            rx_left--;
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        i_m_axis_tready <= 1'b0;
                    end else begin
                        i_m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(5, 30);
                    end
                end
            endcase
        end
    end

    // Pop and compare results, then record newly accepted requests
    always @(posedge i_clk) begin
        rgb_t got, want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = rgb_t'(o_m_axis_tdata);
                if (expected_colors.size() == 0) begin
                    error_count++;
                    $error("color %h arrived with no pending request", got);
                end else begin
                    want = expected_colors.pop_front();
                    if (got.red !== want.red) begin
                        error_count++;
                        $error("red mismatch: expected %0d, got %0d", want.red, got.red);
                    end
                    if (got.green !== want.green) begin
                        error_count++;
                        $error("green mismatch: expected %0d, got %0d",
                               want.green, got.green);
                    end
                    if (got.blue !== want.blue) begin
                        error_count++;
                        $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_colors.push_back(predict_rgb(i_s_axis_tdata[12:0],
                                                      i_s_axis_tdata[23:13],
                                                      i_s_axis_tdata[34:24]));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hsv_to_rgb_converter test failed");
            $finish;
        end
    end

    initial begin
        error_count     = 0;
        cycle_count     = 0;
        tx_mode         = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_sector_edges();
        test_random();

        while (expected_colors.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (error_count == 0)
            $display("hsv_to_rgb_converter test passed");
        else
            $display("hsv_to_rgb_converter test failed");
        $finish;
    end

endmodule

`default_nettype wire
